[rtl/tro_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_pkg
// Shared constants, types and helpers of the wavetable readout interpolator.
// ----------------------------------------------------------------------------
package tro_pkg;

  localparam int MAX_STEPS = 256;
  localparam int NUM_BANKS = 16;
  localparam int DEPTH     = NUM_BANKS * MAX_STEPS;
  localparam int STEP_W    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int BANK_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int STC_W     = 9;
  // wide enough for step indexes and the step count, plus carry room
  localparam int PT_W      = ((STEP_W > STC_W) ? STEP_W : STC_W) + 2;
  localparam int NPTS      = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd2;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef logic [15:0]        word_t;
  typedef logic signed [33:0] cub_t;
  typedef logic [NPTS-1:0][1:0][15:0] pts_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] f;
    logic [7:0]  b;
  } front_ctl_t;

  typedef struct packed {
    logic vld;
    cub_t stepped;
    cub_t linear;
    cub_t smooth;
    cub_t cubic;
  } res_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [BANK_W-1:0] bank,
                                                 input logic [STEP_W-1:0] step);
    return ADDR_W'(int'(bank) * MAX_STEPS + int'(step));
  endfunction

endpackage

[rtl/tro_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_in_if
// Request channel: read or write words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tro_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] read_phase;
  logic [11:0] read_bank;
  logic [3:0]  write_bank;
  logic [7:0]  write_step;
  logic [15:0] write_value;

  modport source(output valid, req_type, read_phase, read_bank, write_bank,
                 write_step, write_value, input ready);
  modport sink(input valid, req_type, read_phase, read_bank, write_bank,
               write_step, write_value, output ready);
endinterface

[rtl/tro_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_out_if
// Result channel: four interpolated Q16.16 values with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tro_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_stepped;
  logic signed [31:0] out_linear;
  logic signed [31:0] out_smooth;
  logic signed [31:0] out_cubic;

  modport source(output valid, out_stepped, out_linear, out_smooth, out_cubic,
                 input ready);
  modport sink(input valid, out_stepped, out_linear, out_smooth, out_cubic,
               output ready);
endinterface

[rtl/tro_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tro_ram #(
  parameter int DEPTH = 4096,
  parameter int DW    = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [DW-1:0]            rdata_a_r,
  output logic [DW-1:0]            rdata_b_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

endmodule

[rtl/tro_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_front
// Phase scaling, neighbor address generation, table clear, table writes and reads.
// ----------------------------------------------------------------------------
module tro_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                in_take,
  input  logic                req_type,
  input  logic [31:0]         read_phase,
  input  logic [11:0]         read_bank,
  input  logic [3:0]          write_bank,
  input  logic [7:0]          write_step,
  input  logic [15:0]         write_value,
  input  logic [8:0]          step_count,
  output logic                busy,
  output tro_pkg::front_ctl_t ctl,
  output tro_pkg::pts_t       rdata
);
  import tro_pkg::*;

  // stage 1
  logic              s1_vld_r, s1_wr_r, s1_wok_r;
  logic [31:0]       s1_phase_r;
  logic [11:0]       s1_rb_r;
  logic [ADDR_W-1:0] s1_waddr_r;
  word_t             s1_wv_r;
  // stage 2
  logic              s2_vld_r, s2_wr_r, s2_wok_r;
  logic [ADDR_W-1:0] s2_waddr_r;
  word_t             s2_wv_r;
  logic [STEP_W-1:0] s2_pt_r;
  logic [15:0]       s2_f_r;
  logic [BANK_W-1:0] s2_ba_r, s2_ba1_r;
  logic [7:0]        s2_b_r;
  logic [STC_W-1:0]  s2_st_r;
  // stage 3 control
  front_ctl_t        ctl_r;
  // clear pass
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [STC_W-1:0]  st;
  logic [40:0]       pos;
  logic [BANK_W-1:0] ba_nxt, ba1_nxt;
  logic [7:0]        b_nxt;
  logic [PT_W-1:0]   t0, t2, t3;
  logic [NPTS-1:0][STEP_W-1:0] pidx;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr;
  word_t             ram_wdata;

  always_comb begin
    st = step_count;
    if (step_count == '0) st = STC_W'(1);
    if (int'(step_count) > MAX_STEPS) st = STC_W'(MAX_STEPS);
  end

  assign pos = 41'(s1_phase_r) * 41'(st);

  always_comb begin
    ba_nxt = BANK_W'(s1_rb_r[11:8]);
    b_nxt  = s1_rb_r[7:0];
    if (int'(s1_rb_r[11:8]) > NUM_BANKS - 1) begin
      ba_nxt = BANK_W'(NUM_BANKS - 1);
      b_nxt  = '0;
    end
    ba1_nxt = (int'(ba_nxt) + 1 > NUM_BANKS - 1) ? ba_nxt : ba_nxt + 1'b1;
  end

  // neighbors: previous wraps to st-1, the next two wrap modulo st
  always_comb begin
    t0 = (s2_pt_r == '0) ? PT_W'(s2_st_r) - 1'b1 : PT_W'(s2_pt_r) - 1'b1;
    t2 = PT_W'(s2_pt_r) + 1'b1;
    if (t2 >= PT_W'(s2_st_r)) t2 = t2 - PT_W'(s2_st_r);
    t3 = PT_W'(s2_pt_r) + PT_W'(2);
    if (t3 >= PT_W'(s2_st_r)) t3 = t3 - PT_W'(s2_st_r);
    if (t3 >= PT_W'(s2_st_r)) t3 = t3 - PT_W'(s2_st_r);
    pidx[0] = STEP_W'(t0);
    pidx[1] = s2_pt_r;
    pidx[2] = STEP_W'(t2);
    pidx[3] = STEP_W'(t3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      ctl_r.vld <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= in_take;
      s2_vld_r <= s1_vld_r;
      ctl_r.vld <= s2_vld_r && (s2_wr_r == REQ_READ);
      ctl_r.f   <= s2_f_r;
      ctl_r.b   <= s2_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_wr_r    <= req_type;
      s1_phase_r <= read_phase;
      s1_rb_r    <= read_bank;
      s1_wok_r   <= (int'(write_bank) < NUM_BANKS) && (int'(write_step) < MAX_STEPS);
      s1_waddr_r <= tbl_addr(BANK_W'(write_bank), STEP_W'(write_step));
      s1_wv_r    <= write_value;
      s2_wr_r    <= s1_wr_r;
      s2_wok_r   <= s1_wok_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wv_r    <= s1_wv_r;
      s2_pt_r    <= STEP_W'(pos[40:32]);
      s2_f_r     <= pos[31:16];
      s2_ba_r    <= ba_nxt;
      s2_ba1_r   <= ba1_nxt;
      s2_b_r     <= b_nxt;
      s2_st_r    <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_comb begin
    ram_we    = clr_busy_r || (advance && s2_vld_r && (s2_wr_r == REQ_WRITE) && s2_wok_r);
    ram_waddr = clr_busy_r ? clr_addr_r : s2_waddr_r;
    ram_wdata = clr_busy_r ? '0 : s2_wv_r;
    ram_re    = advance && s2_vld_r && (s2_wr_r == REQ_READ);
  end

  // one copy per neighbor point, each reading both banks
  for (genvar k = 0; k < NPTS; k++) begin : g_ram
    tro_ram #(.DEPTH(DEPTH), .DW(16)) u_ram (
      .clk      (clk),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ram_re),
      .raddr_a  (tbl_addr(s2_ba_r, pidx[k])),
      .raddr_b  (tbl_addr(s2_ba1_r, pidx[k])),
      .rdata_a_r(rdata[k][0]),
      .rdata_b_r(rdata[k][1])
    );
  end

  assign busy = clr_busy_r;
  assign ctl  = ctl_r;

endmodule

[rtl/tro_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_interp
// Bank mix and stepped, linear, smooth and cubic Hermite interpolation.
// ----------------------------------------------------------------------------
module tro_interp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  tro_pkg::front_ctl_t ctl,
  input  tro_pkg::pts_t       rdata,
  output tro_pkg::res_t       res
);
  import tro_pkg::*;

  // stage 4
  logic              s4_vld_r;
  logic [NPTS-1:0][23:0] s4_y_r;
  logic [15:0]       s4_f_r, s4_q2_r;
  // stage 5
  logic              s5_vld_r;
  logic [23:0]       s5_y1_r, s5_y2_r, s5_lin_r;
  logic [15:0]       s5_f_r, s5_q4_r;
  logic [19:0]       s5_term_r;
  cub_t              s5_a_r, s5_i_r;
  // stage 6
  logic              s6_vld_r;
  logic [23:0]       s6_y1_r, s6_y2_r, s6_lin_r;
  logic [15:0]       s6_f_r;
  logic [16:0]       s6_s_r;
  cub_t              s6_m_r;
  res_t              res_r;

  logic [NPTS-1:0][23:0] y_nxt;
  logic [31:0]       q2p;
  logic [18:0]       q2x5;
  logic [35:0]       termp;
  logic [31:0]       q4p;
  logic [41:0]       linp;
  cub_t              y0s, y1s, y2s, y3s, a, h1, h2, d, i_nxt;
  logic signed [17:0] fs4, fs5, fm, fs6;
  logic signed [51:0] pr1, pr2, pr3;
  logic [31:0]       q5p;
  logic [20:0]       ssum;
  logic [16:0]       s_nxt;
  cub_t              m_nxt, v_nxt;
  logic [41:0]       smp;

  // stage 3: mix the two banks, Q0.24
  always_comb begin
    for (int k = 0; k < NPTS; k++) begin
      y_nxt[k] = 24'(25'(rdata[k][0]) * 25'(9'd256 - 9'(ctl.b))
                   + 25'(rdata[k][1]) * 25'(ctl.b));
    end
    q2p = 32'(ctl.f) * 32'(ctl.f);
  end

  // stage 4: linear, smooth terms, first Hermite step
  always_comb begin
    q2x5  = 19'(s4_q2_r) * 19'd5;
    termp = 36'(q2x5) * 36'(17'h10000 - 17'(s4_f_r));
    q4p   = 32'(s4_q2_r) * 32'(s4_q2_r);
    linp  = 42'(s4_y_r[1]) * 42'(17'h10000 - 17'(s4_f_r))
          + 42'(s4_y_r[2]) * 42'(s4_f_r);
    y0s   = cub_t'({10'b0, s4_y_r[0]});
    y1s   = cub_t'({10'b0, s4_y_r[1]});
    y2s   = cub_t'({10'b0, s4_y_r[2]});
    y3s   = cub_t'({10'b0, s4_y_r[3]});
    a     = (y2s - y1s) <<< 1;
    h1    = y2s - y0s;
    h2    = y3s - y1s;
    d     = h2 - a;
    fs4   = signed'({2'b0, s4_f_r});
    pr1   = d * fs4;
    i_nxt = a - h1 + cub_t'(pr1 >>> 16);
  end

  // stage 5: smooth weight, second Hermite step
  always_comb begin
    q5p   = 32'(s5_q4_r) * 32'(s5_f_r);
    ssum  = 21'(s5_term_r) + 21'(q5p[31:16]);
    s_nxt = (ssum > 21'h10000) ? 17'h10000 : 17'(ssum);
    fs5   = signed'({2'b0, s5_f_r});
    fm    = fs5 - 18'sd65536;
    pr2   = s5_i_r * fm;
    m_nxt = s5_a_r + cub_t'(pr2 >>> 16);
  end

  // stage 6: smooth blend and final Hermite step (twice the value, Q0.25)
  always_comb begin
    smp   = 42'(s6_y1_r) * 42'(17'h10000 - s6_s_r) + 42'(s6_y2_r) * 42'(s6_s_r);
    fs6   = signed'({2'b0, s6_f_r});
    pr3   = s6_m_r * fs6;
    v_nxt = (cub_t'({10'b0, s6_y1_r}) <<< 1) + cub_t'(pr3 >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r  <= 1'b0;
      s5_vld_r  <= 1'b0;
      s6_vld_r  <= 1'b0;
      res_r.vld <= 1'b0;
    end else if (advance) begin
      s4_vld_r      <= ctl.vld;
      s5_vld_r      <= s4_vld_r;
      s6_vld_r      <= s5_vld_r;
      res_r.vld     <= s6_vld_r;
      res_r.stepped <= cub_t'({10'b0, s6_y1_r});
      res_r.linear  <= cub_t'({10'b0, s6_lin_r});
      res_r.smooth  <= cub_t'({10'b0, smp[39:16]});
      res_r.cubic   <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_y_r        <= y_nxt;
      s4_f_r        <= ctl.f;
      s4_q2_r       <= q2p[31:16];
      s5_y1_r       <= s4_y_r[1];
      s5_y2_r       <= s4_y_r[2];
      s5_lin_r      <= linp[39:16];
      s5_f_r        <= s4_f_r;
      s5_q4_r       <= q4p[31:16];
      s5_term_r     <= termp[35:16];
      s5_a_r        <= a;
      s5_i_r        <= i_nxt;
      s6_y1_r       <= s5_y1_r;
      s6_y2_r       <= s5_y2_r;
      s6_lin_r      <= s5_lin_r;
      s6_f_r        <= s5_f_r;
      s6_s_r        <= s_nxt;
      s6_m_r        <= m_nxt;
    end
  end

  assign res = res_r;

endmodule

[rtl/tro_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tro_scale
// Gain, offset and 32-bit saturation, ending in the output register.
// ----------------------------------------------------------------------------
module tro_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  tro_pkg::res_t      res,
  input  logic signed [31:0] amplitude,
  input  logic signed [31:0] offset,
  output logic               out_vld,
  output logic signed [31:0] out_stepped,
  output logic signed [31:0] out_linear,
  output logic signed [31:0] out_smooth,
  output logic signed [31:0] out_cubic
);
  import tro_pkg::*;

  logic               p_vld_r;
  logic signed [65:0] p_r [NPTS];
  logic               o_vld_r;
  logic signed [31:0] o_r [NPTS];

  logic signed [65:0] p_nxt [NPTS];
  logic signed [31:0] o_nxt [NPTS];
  logic signed [66:0] sum;

  always_comb begin
    p_nxt[0] = amplitude * res.stepped;
    p_nxt[1] = amplitude * res.linear;
    p_nxt[2] = amplitude * res.smooth;
    p_nxt[3] = amplitude * res.cubic;
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NPTS; k++) begin
      // cubic carries one extra fraction bit
      if (k == NPTS - 1) sum = 67'(offset) + 67'(p_r[k] >>> 25);
      else               sum = 67'(offset) + 67'(p_r[k] >>> 24);
      if (sum > 67'sd2147483647)        o_nxt[k] = 32'sh7FFFFFFF;
      else if (sum < -67'sd2147483648)  o_nxt[k] = 32'sh80000000;
      else                              o_nxt[k] = 32'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (advance) begin
      p_vld_r <= res.vld;
      o_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_r <= p_nxt;
      o_r <= o_nxt;
    end
  end

  assign out_vld     = o_vld_r;
  assign out_stepped = o_r[0];
  assign out_linear  = o_r[1];
  assign out_smooth  = o_r[2];
  assign out_cubic   = o_r[3];

endmodule

[rtl/table_readout_interpolator.sv]
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled and no clear runs;
// four table copies serve the eight reads of a word together.
// Writes take effect in pipeline order and return no result.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all 4096 table
// words, during which no request is accepted (configuration writes still are).
// ----------------------------------------------------------------------------
// table_readout_interpolator
// Multi-bank wavetable with stepped, linear, smooth and cubic Hermite readout.
// ----------------------------------------------------------------------------
module table_readout_interpolator (
  input  logic                           clk,
  input  logic                           rst_n,
  tro_in_if.sink                         in_ch,
  tro_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tro_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);
  import tro_pkg::*;

  logic [STC_W-1:0]   step_count_r;
  logic signed [31:0] amplitude_r, offset_r;
  logic               advance, busy, out_vld;
  front_ctl_t         ctl;
  pts_t               rdata;
  res_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= STC_W'(16);
      amplitude_r  <= 32'sd65536;
      offset_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_COUNT: step_count_r <= cfg_wdata[STC_W-1:0];
        CFG_AMPLITUDE:  amplitude_r  <= signed'(cfg_wdata);
        CFG_OFFSET:     offset_r     <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // the whole pipe moves unless a result word is stuck at the output
  assign advance      = !out_vld || out_ch.ready;
  assign in_ch.ready  = advance && !busy;
  assign out_ch.valid = out_vld;

  tro_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .in_take    (in_ch.valid && in_ch.ready),
    .req_type   (in_ch.req_type),
    .read_phase (in_ch.read_phase),
    .read_bank  (in_ch.read_bank),
    .write_bank (in_ch.write_bank),
    .write_step (in_ch.write_step),
    .write_value(in_ch.write_value),
    .step_count (step_count_r),
    .busy       (busy),
    .ctl        (ctl),
    .rdata      (rdata)
  );

  tro_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .ctl    (ctl),
    .rdata  (rdata),
    .res    (res)
  );

  tro_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .res        (res),
    .amplitude  (amplitude_r),
    .offset     (offset_r),
    .out_vld    (out_vld),
    .out_stepped(out_ch.out_stepped),
    .out_linear (out_ch.out_linear),
    .out_smooth (out_ch.out_smooth),
    .out_cubic  (out_ch.out_cubic)
  );

  a_no_take_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ch.ready)
    else $error("request taken during table clear");

  a_no_result_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_ch.valid)
    else $error("result word while table clear runs");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(res) && $stable(ctl.vld))
    else $error("pipeline moved during output stall");

endmodule
